FILE: hdl/rqtw_pkg.sv
// ----------------------------------------------------------------------------
// rqtw_pkg
// Shared types, constants and width helpers for the read quality trimmer.
// ----------------------------------------------------------------------------
package rqtw_pkg;

   localparam int DEF_MAX_READ_LEN = 1024;
   localparam int CSR_INDEX_W      = 3;
   localparam int CSR_DATA_W       = 11;
   localparam int PCT_SCALE        = 100;
   localparam int PCT_W            = 7;

   localparam logic [CSR_INDEX_W-1:0] CSR_TRIM_MODE         = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_POSITION    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUALITY_THRESHOLD = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MINIMUM_LENGTH    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MINIMUM_PERCENT   = 3'd4;

   typedef enum logic [1:0] {
      STATUS_KEPT     = 2'd0,
      STATUS_DISCARD  = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] quality_byte;
      logic       last_base;
   } req_item_type;

   typedef struct packed {
      status_type  status;
      logic [9:0]  trim_start;
      logic [10:0] trim_length;
   } rsp_item_type;

   typedef struct packed {
      logic        trim_mode;
      logic [9:0]  first_position;
      logic [7:0]  quality_threshold;
      logic [10:0] minimum_length;
      logic [6:0]  minimum_percent;
   } cfg_type;

   // position width: holds the read length limit and every register value
   function automatic int pos_width(int max_len);
      int w;
      w = $clog2(max_len + 1);
      return (w < 11) ? 11 : w;
   endfunction

   // read summary: two flags and six position-wide fields
   function automatic int summary_width(int pw);
      return 2 + 6 * pw;
   endfunction

endpackage

FILE: hdl/read_quality_trim_window.sv
// ----------------------------------------------------------------------------
// read_quality_trim_window
// Quality trimming of sequencing reads: one verdict per read.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive req_item (quality byte, last flag) with push; an item
//   goes in at a clock edge with push high and full low. One base per cycle.
//   Result queue: while empty is low, rsp_item holds the oldest verdict
//   (status, trim start, trim length); pop high with empty low takes it.
//   Settings: csr_index/csr_data with csr_valid; csr_ready is always high.
//   Write them only while no read is in flight.
// Timing:
//   Bases stream at one per cycle while full is low. A verdict reaches the
//   result ports through the summary queue write, then the verdict stage,
//   then the result register, and can be taken at the next edge.
//   Verdicts leave at up to one per cycle, so reads of one base each also
//   run at full rate.
// Reset: synchronous; clears the scan state, queues and settings to defaults.
// Stall: when the receiver holds off, the result register, the verdict stage
//   and the two-entry summary queue fill; full then rises and the input stops
//   until pop.
// ----------------------------------------------------------------------------
module read_quality_trim_window #(
   parameter int MAX_READ_LEN = rqtw_pkg::DEF_MAX_READ_LEN
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rqtw_pkg::req_item_type               req_item,
   input  logic                                 push,
   output logic                                 full,
   output rqtw_pkg::rsp_item_type               rsp_item,
   output logic                                 empty,
   input  logic                                 pop,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rqtw_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rqtw_pkg::CSR_DATA_W-1:0]      csr_data
);

   import rqtw_pkg::*;

   localparam int PW = pos_width(MAX_READ_LEN);
   localparam int SW = summary_width(PW);

   cfg_type       cfg_ff, cfg_in;
   logic          sum_push, sum_full, sum_pop, sum_empty;
   logic [SW-1:0] sum_wdata, sum_rdata;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TRIM_MODE:         cfg_in.trim_mode         = csr_data[0];
            CSR_FIRST_POSITION:    cfg_in.first_position    = csr_data[9:0];
            CSR_QUALITY_THRESHOLD: cfg_in.quality_threshold = csr_data[7:0];
            CSR_MINIMUM_LENGTH:    cfg_in.minimum_length    = csr_data[10:0];
            CSR_MINIMUM_PERCENT:   cfg_in.minimum_percent   = csr_data[6:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trim_mode         <= 1'b0;
         cfg_ff.first_position    <= 10'd0;
         cfg_ff.quality_threshold <= 8'd84;
         cfg_ff.minimum_length    <= 11'd30;
         cfg_ff.minimum_percent   <= 7'd50;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rqtw_front #(
      .MAX_READ_LEN(MAX_READ_LEN)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_item (req_item),
      .push     (push),
      .full     (full),
      .sum_push (sum_push),
      .sum_data (sum_wdata),
      .sum_full (sum_full)
   );

   rqtw_fifo #(
      .WIDTH(SW),
      .DEPTH(2)
   ) u_sum_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (sum_push),
      .push_data (sum_wdata),
      .full      (sum_full),
      .pop       (sum_pop),
      .pop_data  (sum_rdata),
      .empty     (sum_empty)
   );

   rqtw_back #(
      .MAX_READ_LEN(MAX_READ_LEN)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .sum_data  (sum_rdata),
      .sum_empty (sum_empty),
      .sum_pop   (sum_pop),
      .rsp_item  (rsp_item),
      .empty     (empty),
      .pop       (pop)
   );

endmodule

FILE: hdl/rqtw_fifo.sv
// ----------------------------------------------------------------------------
// rqtw_fifo
// Small synchronous queue between the base scanner and the verdict stage.
// ----------------------------------------------------------------------------
module rqtw_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hdl/rqtw_front.sv
// ----------------------------------------------------------------------------
// rqtw_front
// Base scanner: one byte per cycle while sum_full is low; builds a read summary.
// ----------------------------------------------------------------------------
module rqtw_front #(
   parameter int MAX_READ_LEN = rqtw_pkg::DEF_MAX_READ_LEN,
   localparam int PW = rqtw_pkg::pos_width(MAX_READ_LEN),
   localparam int SW = rqtw_pkg::summary_width(PW)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rqtw_pkg::cfg_type      cfg,
   input  rqtw_pkg::req_item_type req_item,
   input  logic                   push,
   output logic                   full,
   output logic                   sum_push,
   output logic [SW-1:0]          sum_data,
   input  logic                   sum_full
);

   import rqtw_pkg::*;

   typedef struct packed {
      logic          overflow;
      logic          any_good;
      logic [PW-1:0] base_count;
      logic [PW-1:0] run_begin;
      logic [PW-1:0] best_begin;
      logic [PW-1:0] best_length;
      logic [PW-1:0] last_good;
      logic [PW-1:0] good_count;
   } summary_type;

   logic [PW-1:0] pos_ff, pos_in;
   logic [PW-1:0] run_begin_ff, run_begin_in;
   logic [PW-1:0] best_begin_ff, best_begin_in;
   logic [PW-1:0] best_len_ff, best_len_in;
   logic [PW-1:0] last_good_ff, last_good_in;
   logic [PW-1:0] good_cnt_ff, good_cnt_in;
   logic          any_good_ff, any_good_in;
   logic          ovf_ff, ovf_in;

   logic          accept;
   logic [PW-1:0] first;
   logic [PW-1:0] rb;
   logic [PW-1:0] run_len;
   logic          in_window, good, poor;
   summary_type   summary;

   assign full     = sum_full;
   assign accept   = push & ~sum_full;
   assign sum_push = accept & req_item.last_base;
   assign sum_data = summary;

   assign first     = PW'(cfg.first_position);
   assign rb        = (pos_ff == '0) ? first : run_begin_ff;
   assign in_window = (pos_ff >= first);
   assign good      = (req_item.quality_byte >= cfg.quality_threshold);
   assign poor      = (req_item.quality_byte <= cfg.quality_threshold);
   assign run_len   = (pos_ff >= rb) ? pos_ff - rb : '0;

   always_comb begin
      pos_in        = pos_ff;
      run_begin_in  = run_begin_ff;
      best_begin_in = best_begin_ff;
      best_len_in   = best_len_ff;
      last_good_in  = last_good_ff;
      good_cnt_in   = good_cnt_ff;
      any_good_in   = any_good_ff;
      ovf_in        = ovf_ff;

      if (accept && !ovf_ff) begin
         if (pos_ff >= PW'(MAX_READ_LEN)) begin
            ovf_in = 1'b1;
         end else begin
            run_begin_in = rb;
            if (in_window) begin
               if (good) begin
                  any_good_in  = 1'b1;
                  last_good_in = pos_ff;
                  good_cnt_in  = good_cnt_ff + PW'(1);
               end
               if (poor) begin
                  if (run_len > best_len_ff) begin
                     best_len_in   = run_len;
                     best_begin_in = rb;
                  end
                  run_begin_in = pos_ff + PW'(1);
               end
            end
            pos_in = pos_ff + PW'(1);
         end
      end

      summary.overflow    = ovf_in;
      summary.any_good    = any_good_in;
      summary.base_count  = pos_in;
      summary.run_begin   = run_begin_in;
      summary.best_begin  = best_begin_in;
      summary.best_length = best_len_in;
      summary.last_good   = last_good_in;
      summary.good_count  = good_cnt_in;

      // end of read: start the next one clean
      if (sum_push) begin
         pos_in        = '0;
         run_begin_in  = '0;
         best_begin_in = '0;
         best_len_in   = '0;
         last_good_in  = '0;
         good_cnt_in   = '0;
         any_good_in   = 1'b0;
         ovf_in        = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         run_begin_ff  <= '0;
         best_begin_ff <= '0;
         best_len_ff   <= '0;
         last_good_ff  <= '0;
         good_cnt_ff   <= '0;
         any_good_ff   <= 1'b0;
         ovf_ff        <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         run_begin_ff  <= run_begin_in;
         best_begin_ff <= best_begin_in;
         best_len_ff   <= best_len_in;
         last_good_ff  <= last_good_in;
         good_cnt_ff   <= good_cnt_in;
         any_good_ff   <= any_good_in;
         ovf_ff        <= ovf_in;
      end
   end

endmodule

FILE: hdl/rqtw_back.sv
// ----------------------------------------------------------------------------
// rqtw_back
// Verdict stage: ends last run, checks length and mode-0 percent, holds result.
// ----------------------------------------------------------------------------
module rqtw_back #(
   parameter int MAX_READ_LEN = rqtw_pkg::DEF_MAX_READ_LEN,
   localparam int PW = rqtw_pkg::pos_width(MAX_READ_LEN),
   localparam int SW = rqtw_pkg::summary_width(PW)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rqtw_pkg::cfg_type      cfg,
   input  logic [SW-1:0]          sum_data,
   input  logic                   sum_empty,
   output logic                   sum_pop,
   output rqtw_pkg::rsp_item_type rsp_item,
   output logic                   empty,
   input  logic                   pop
);

   import rqtw_pkg::*;

   localparam int MW = PW + PCT_W;

   typedef struct packed {
      logic          overflow;
      logic          any_good;
      logic [PW-1:0] base_count;
      logic [PW-1:0] run_begin;
      logic [PW-1:0] best_begin;
      logic [PW-1:0] best_length;
      logic [PW-1:0] last_good;
      logic [PW-1:0] good_count;
   } summary_type;

   summary_type   s;
   logic [PW-1:0] first;
   logic [PW-1:0] fin_len;
   logic          fin_close;
   logic [PW-1:0] best_len;
   logic [PW-1:0] best_begin;
   logic          tail_pre;
   logic [PW-1:0] tail_len;

   logic          s1_valid_ff, s1_valid_in;
   logic          s1_ovf_ff;
   logic          s1_tail_ff;
   logic [PW-1:0] s1_len_ff;
   logic [MW-1:0] s1_good_ff;
   logic [MW-1:0] s1_need_ff;
   logic [PW-1:0] s1_begin_ff;
   logic [PW-1:0] s1_best_ff;
   logic          s1_adv;

   logic          out_valid_ff, out_valid_in;
   rsp_item_type  out_item_ff, out_item_in;
   logic          run_ok;

   assign s     = summary_type'(sum_data);
   assign first = PW'(cfg.first_position);

   // final close of the open run at the read end
   assign fin_close  = (s.base_count >= first);
   assign fin_len    = (s.base_count >= s.run_begin) ? s.base_count - s.run_begin : '0;
   assign best_len   = (fin_close && fin_len > s.best_length) ? fin_len : s.best_length;
   assign best_begin = (fin_close && fin_len > s.best_length) ? s.run_begin : s.best_begin;

   assign tail_pre = s.any_good && (s.last_good >= first)
                     && (s.last_good >= PW'(cfg.minimum_length));
   assign tail_len = s.last_good - first + PW'(1);

   assign s1_adv  = s1_valid_ff & (~out_valid_ff | pop);
   assign sum_pop = ~sum_empty & (~s1_valid_ff | s1_adv);

   assign s1_valid_in  = sum_pop | (s1_valid_ff & ~s1_adv);
   assign out_valid_in = s1_adv | (out_valid_ff & ~pop);

   assign run_ok = (s1_best_ff != '0) && (s1_best_ff >= PW'(cfg.minimum_length));

   always_comb begin
      out_item_in             = out_item_ff;
      if (s1_adv) begin
         out_item_in.status      = STATUS_DISCARD;
         out_item_in.trim_start  = '0;
         out_item_in.trim_length = '0;
         if (s1_ovf_ff) begin
            out_item_in.status = STATUS_OVERFLOW;
         end else if (!cfg.trim_mode) begin
            if (s1_tail_ff && (s1_good_ff >= s1_need_ff)) begin
               out_item_in.status      = STATUS_KEPT;
               out_item_in.trim_start  = cfg.first_position;
               out_item_in.trim_length = s1_len_ff[10:0];
            end
         end else if (run_ok) begin
            out_item_in.status      = STATUS_KEPT;
            out_item_in.trim_start  = s1_begin_ff[9:0];
            out_item_in.trim_length = s1_best_ff[10:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sum_pop) begin
         s1_ovf_ff   <= s.overflow;
         s1_tail_ff  <= tail_pre;
         s1_len_ff   <= tail_len;
         s1_good_ff  <= MW'(s.good_count) * MW'(PCT_SCALE);
         s1_need_ff  <= MW'(cfg.minimum_percent) * MW'(tail_len);
         s1_begin_ff <= best_begin;
         s1_best_ff  <= best_len;
      end
      out_item_ff <= out_item_in;
   end

   assign rsp_item = out_item_ff;
   assign empty    = ~out_valid_ff;

endmodule
